FILE: sv/trcq_pkg.sv
// Shared constants, types and helpers of the common-rank query core.
package trcq_pkg;

	localparam int NODE_COUNT  = 4096;
	localparam int MAX_DEPTH   = 64;
	localparam int RANK_LEVELS = 9;

	localparam int ID_W   = 12;
	localparam int RANK_W = 4;
	localparam int RES_W  = 5;

	localparam int STORE_DEPTH = (NODE_COUNT < (1 << ID_W)) ? NODE_COUNT : (1 << ID_W);
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int STEP_W      = $clog2(MAX_DEPTH + 1);

	localparam logic              OP_WRITE  = 1'b0;
	localparam logic              OP_QUERY  = 1'b1;
	localparam logic signed [RES_W-1:0] RANK_NONE = -5'sd1;

	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
	} lin_entry_t;

	typedef struct packed {
		logic load;       // capture a new transaction
		logic walk_init;  // begin a parent walk
		logic walk_step;  // consume one table entry of the walk
		logic sel_b;      // walk works on the second lineage
		logic set_deep;   // note that the depth bound was hit
		logic res_write;  // load the result of a write
		logic res_scan;   // load the result of the rank scan
	} trcq_cmd_t;

	typedef struct packed {
		logic is_query;
		logic start_live;
		logic next_live;
		logic depth_hit;
	} trcq_status_t;

	// Node takes part in a walk: not the root and inside the table.
	function automatic logic node_live(input logic [ID_W-1:0] id);
		node_live = (id != '0) && (32'(id) < NODE_COUNT);
	endfunction

	function automatic logic node_stored(input logic [ID_W-1:0] id);
		node_stored = (32'(id) < NODE_COUNT);
	endfunction

endpackage

FILE: sv/trcq_ctrl.sv
// Sequencer of the common-rank query core: walks, scan and result strobe.
module trcq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  trcq_pkg::trcq_status_t status,
	output trcq_pkg::trcq_cmd_t    cmd,
	output logic                  busy,
	output logic                  done
);
	import trcq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START_A,
		S_WALK_A,
		S_START_B,
		S_WALK_B,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (status.is_query) begin
						state_d = S_START_A;
					end else begin
						cmd.res_write = 1'b1;
						state_d       = S_DONE;
					end
				end
			end
			S_START_A: begin
				cmd.walk_init = 1'b1;
				state_d       = status.start_live ? S_WALK_A : S_START_B;
			end
			S_WALK_A: begin
				cmd.walk_step = 1'b1;
				if (!status.next_live) begin
					state_d = S_START_B;
				end else if (status.depth_hit) begin
					cmd.set_deep = 1'b1;
					state_d      = S_START_B;
				end
			end
			S_START_B: begin
				cmd.walk_init = 1'b1;
				cmd.sel_b     = 1'b1;
				state_d       = status.start_live ? S_WALK_B : S_SCAN;
			end
			S_WALK_B: begin
				cmd.walk_step = 1'b1;
				cmd.sel_b     = 1'b1;
				if (!status.next_live) begin
					state_d = S_SCAN;
				end else if (status.depth_hit) begin
					cmd.set_deep = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.res_scan = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= (state_d == S_DONE);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

FILE: sv/trcq_dp.sv
// Datapath of the common-rank query core: node table, lineages and rank scan.
module trcq_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  trcq_pkg::trcq_cmd_t               cmd,
	output trcq_pkg::trcq_status_t            status,
	input  logic                              operation,
	input  logic [trcq_pkg::ID_W-1:0]         node_id,
	input  logic [trcq_pkg::ID_W-1:0]         parent_node,
	input  logic [trcq_pkg::RANK_W-1:0]       rank_code,
	input  logic [trcq_pkg::ID_W-1:0]         other_node,
	output logic signed [trcq_pkg::RES_W-1:0] common_rank,
	output logic                              depth_exceeded
);
	import trcq_pkg::*;

	// Node table: rank code above parent id.
	logic [RANK_W+ID_W-1:0] mem_q [STORE_DEPTH];
	logic [RANK_W+ID_W-1:0] rdata_q;
	logic [ID_W-1:0]        rd_addr;

	logic [ID_W-1:0]   node_q;
	logic [ID_W-1:0]   other_q;
	logic [ID_W-1:0]   cur_q;
	logic [STEP_W-1:0] steps_q;
	logic              deep_q;
	lin_entry_t        lin_a_q [RANK_LEVELS];
	lin_entry_t        lin_b_q [RANK_LEVELS];

	logic signed [RES_W-1:0] res_rank_q;
	logic                    res_deep_q;

	logic [ID_W-1:0]   start_id;
	logic [ID_W-1:0]   up_id;
	logic [ID_W-1:0]   nxt_id;
	logic [RANK_W-1:0] rd_rank;
	logic signed [RES_W-1:0] scan_rank;

	assign start_id = cmd.sel_b ? other_q : node_q;
	assign up_id    = rdata_q[ID_W-1:0];
	assign rd_rank  = rdata_q[RANK_W+ID_W-1:ID_W];
	// A self-parent ends the walk like the root.
	assign nxt_id   = (up_id == cur_q) ? '0 : up_id;
	assign rd_addr  = cmd.walk_init ? start_id : nxt_id;

	assign status.is_query   = (operation == OP_QUERY);
	assign status.start_live = node_live(start_id);
	assign status.next_live  = node_live(nxt_id);
	assign status.depth_hit  = ((steps_q + STEP_W'(1)) == STEP_W'(MAX_DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.load && (operation == OP_WRITE) && node_stored(node_id)) begin
			mem_q[node_id[ADDR_W-1:0]] <= {rank_code, parent_node};
		end
		rdata_q <= mem_q[rd_addr[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			node_q  <= node_id;
			other_q <= other_node;
		end
		if (cmd.walk_init) begin
			cur_q   <= start_id;
			steps_q <= '0;
		end else if (cmd.walk_step) begin
			cur_q   <= nxt_id;
			steps_q <= steps_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deep_q <= 1'b0;
			for (int k = 0; k < RANK_LEVELS; k++) begin
				lin_a_q[k] <= '0;
				lin_b_q[k] <= '0;
			end
		end else begin
			if (cmd.load) begin
				deep_q <= 1'b0;
			end else if (cmd.set_deep) begin
				deep_q <= 1'b1;
			end
			if (cmd.walk_init) begin
				for (int k = 0; k < RANK_LEVELS; k++) begin
					if (cmd.sel_b) begin
						lin_b_q[k] <= '0;
					end else begin
						lin_a_q[k] <= '0;
					end
				end
			end else if (cmd.walk_step && (32'(rd_rank) < RANK_LEVELS)) begin
				// Later entries lie nearer the root and overwrite earlier ones.
				if (cmd.sel_b) begin
					lin_b_q[rd_rank] <= '{valid: 1'b1, id: cur_q};
				end else begin
					lin_a_q[rd_rank] <= '{valid: 1'b1, id: cur_q};
				end
			end
		end
	end

	// Deepest shared rank; the first mismatch where both sides hold a node stops the scan.
	always_comb begin
		logic stop;
		stop      = 1'b0;
		scan_rank = RANK_NONE;
		for (int k = 0; k < RANK_LEVELS; k++) begin
			if (!stop && lin_a_q[k].valid && lin_b_q[k].valid) begin
				if (lin_a_q[k].id != lin_b_q[k].id) begin
					stop = 1'b1;
				end else begin
					scan_rank = $signed(RES_W'(k));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_write) begin
			res_rank_q <= RANK_NONE;
			res_deep_q <= 1'b0;
		end else if (cmd.res_scan) begin
			res_rank_q <= scan_rank;
			res_deep_q <= deep_q;
		end
	end

	assign common_rank    = res_rank_q;
	assign depth_exceeded = res_deep_q;

endmodule

FILE: sv/tree_common_rank_query_core.sv
// Common-rank query core: a write goes straight to its result; a query walks the parents of each node
// in turn (at most MAX_DEPTH nodes per walk), then runs the rank scan before its result.
// One node-table read per walk step sets the pace; a new transaction is taken once busy falls.
// The result is shown for one cycle with done; the receiver cannot stall it.
// arst_n clears the sequencer and the lineages; the node table holds no reset value.
module tree_common_rank_query_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              operation,
	input  logic [trcq_pkg::ID_W-1:0]         node_id,
	input  logic [trcq_pkg::ID_W-1:0]         parent_node,
	input  logic [trcq_pkg::RANK_W-1:0]       rank_code,
	input  logic [trcq_pkg::ID_W-1:0]         other_node,
	output logic                              done,
	output logic signed [trcq_pkg::RES_W-1:0] common_rank,
	output logic                              depth_exceeded
);
	import trcq_pkg::*;

	trcq_cmd_t    cmd;
	trcq_status_t status;

	trcq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	trcq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.operation      (operation),
		.node_id        (node_id),
		.parent_node    (parent_node),
		.rank_code      (rank_code),
		.other_node     (other_node),
		.common_rank    (common_rank),
		.depth_exceeded (depth_exceeded)
	);

`ifndef ASSERT_OFF
	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a transaction");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_WRITE)) |=>
			(done && (common_rank == RANK_NONE) && !depth_exceeded))
		else $error("write transaction gave a wrong result");

	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((common_rank >= RANK_NONE) &&
			(common_rank < $signed(RES_W'(RANK_LEVELS)))))
		else $error("common rank out of range");
`endif

endmodule
